// ===== hdl/lfstr_pkg.sv =====
`default_nettype none

package lfstr_pkg;

  // width of the reported chain length
  localparam int LONGEST_W = 13;

  // sequence tag stored next to every table entry
  localparam int EPOCH_W = 8;

  typedef logic [EPOCH_W-1:0] epoch_t;

  localparam epoch_t EPOCH_FIRST = epoch_t'(1);
  localparam epoch_t EPOCH_LAST  = '1;

  typedef struct packed {
    logic [LONGEST_W-1:0] longest;
    logic                 saturated;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/longest_fixed_step_run_tracker_core.sv =====
// throughput: one transaction per cycle when no sweep runs and results drain, set by one
//   table read and one table write per item with a one-entry bypass of the entry just
//   written; a result passes the queue, the execute stage and the result buffer
// reset: step returns to 1; a clearing sweep over all 2**VALUE_BITS table entries runs
//   after reset and again after every 255th sequence; no item is processed during it and
//   the input stalls once the queue holds two transactions
`default_nettype none

module longest_fixed_step_run_tracker_core import lfstr_pkg::*; #(
  parameter int VALUE_BITS = 12,
  parameter int MAX_LEN    = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration: step register
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [VALUE_BITS-1:0] cfg_step_i,
  // item channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [VALUE_BITS-1:0] value_i,
  input  wire logic                  is_last_i,
  // result channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [LONGEST_W-1:0]  longest_o,
  output logic                       saturated_o
);

  localparam int QW = 2 * VALUE_BITS + 2;

  logic [VALUE_BITS-1:0] pred_idx, val_idx;
  logic                  pred_ok;
  logic [QW-1:0]         head_data;
  logic                  head_valid, pop, q_full;
  result_t               result;

  // the step register is always writable
  assign cfg_ready_o = 1'b1;

  // front: classify the item (predecessor index and range check)
  lfstr_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_step_i  (cfg_step_i),
    .value_i     (value_i),
    .pred_idx_o  (pred_idx),
    .pred_ok_o   (pred_ok),
    .val_idx_o   (val_idx)
  );

  // decoupling queue; the input side stalls only when it is full
  lfstr_fifo #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_valid_i),
    .push_data_i  ({is_last_i, pred_ok, pred_idx, val_idx}),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_data_o  (head_data),
    .pop_i        (pop)
  );

  assign in_stall_o = q_full;

  // back: table lookup, chain update, best tracking and result buffer
  lfstr_back #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_LEN    (MAX_LEN)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_pred_idx_i (head_data[2*VALUE_BITS-1:VALUE_BITS]),
    .head_pred_ok_i  (head_data[2*VALUE_BITS]),
    .head_val_idx_i  (head_data[VALUE_BITS-1:0]),
    .head_last_i     (head_data[QW-1]),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_result_o    (result),
    .out_stall_i     (out_stall_i)
  );

  assign longest_o   = result.longest;
  assign saturated_o = result.saturated;

endmodule

`default_nettype wire

// ===== hdl/lfstr_ram.sv =====
`default_nettype none

module lfstr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lfstr_fifo.sv =====
`default_nettype none

module lfstr_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  output logic                  head_valid_o,
  output logic      [WIDTH-1:0] head_data_o,
  input  wire logic             pop_i
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o       = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_data_o  = slot_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lfstr_front.sv =====
`default_nettype none

module lfstr_front #(
  parameter int VALUE_BITS = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic [VALUE_BITS-1:0] cfg_step_i,
  input  wire logic [VALUE_BITS-1:0] value_i,
  output logic      [VALUE_BITS-1:0] pred_idx_o,
  output logic                       pred_ok_o,
  output logic      [VALUE_BITS-1:0] val_idx_o
);

  logic [VALUE_BITS-1:0] step_q;
  logic [VALUE_BITS:0]   diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= VALUE_BITS'(1);
    end else if (cfg_valid_i) begin
      step_q <= cfg_step_i;
    end
  end

  // sign-extended difference, one guard bit catches overflow
  assign diff = {value_i[VALUE_BITS-1], value_i} - {step_q[VALUE_BITS-1], step_q};

  assign pred_ok_o  = (diff[VALUE_BITS] == diff[VALUE_BITS-1]);
  // offset binary: flip the sign bit
  assign pred_idx_o = {~diff[VALUE_BITS-1], diff[VALUE_BITS-2:0]};
  assign val_idx_o  = {~value_i[VALUE_BITS-1], value_i[VALUE_BITS-2:0]};

endmodule

`default_nettype wire

// ===== hdl/lfstr_back.sv =====
`default_nettype none

module lfstr_back import lfstr_pkg::*; #(
  parameter int VALUE_BITS = 12,
  parameter int MAX_LEN    = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  head_valid_i,
  input  wire logic [VALUE_BITS-1:0] head_pred_idx_i,
  input  wire logic                  head_pred_ok_i,
  input  wire logic [VALUE_BITS-1:0] head_val_idx_i,
  input  wire logic                  head_last_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  output result_t                    out_result_o,
  input  wire logic                  out_stall_i
);

  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int WORD_W = EPOCH_W + LEN_W;
  localparam int DEPTH  = 1 << VALUE_BITS;
  localparam logic [LEN_W-1:0] LenMax  = LEN_W'(MAX_LEN);
  localparam logic [LEN_W-1:0] LenEdge = LEN_W'(MAX_LEN - 1);
  localparam logic [LEN_W-1:0] LenOne  = LEN_W'(1);

  // clearing sweep and sequence tag
  logic                  clr_active_q;
  logic [VALUE_BITS-1:0] clr_addr_q;
  epoch_t                epoch_q;

  // execute stage
  logic                  ex_valid_q, ex_last_q, ex_pred_ok_q;
  logic [VALUE_BITS-1:0] ex_pred_idx_q, ex_val_idx_q;

  // bypass of the entry written in the previous cycle
  logic                  fwd_valid_q;
  logic [VALUE_BITS-1:0] fwd_addr_q;
  logic [WORD_W-1:0]     fwd_word_q;

  logic [LEN_W-1:0]      best_q;
  logic                  hit_q;

  // two-entry result buffer
  result_t               obuf_q [2];
  logic                  owr_q, ord_q;
  logic [1:0]            ocnt_q;

  logic [WORD_W-1:0]     rdata, word, wr_word, ram_wdata;
  logic [VALUE_BITS-1:0] ram_waddr;
  logic                  ram_we;
  logic                  prev_ok, hit_now, wrap_hold, room, res_push, out_pop;
  logic [LEN_W-1:0]      plen, len, best_new;
  logic                  hit_new;
  logic [LEN_W+LONGEST_W-1:0] best_ext;

  assign out_valid_o  = (ocnt_q != 2'd0);
  assign out_result_o = obuf_q[ord_q];
  assign out_pop      = out_valid_o && !out_stall_i;
  assign res_push     = ex_valid_q && ex_last_q;

  // hold the issue side while the tag wraps, so no read crosses a sweep
  assign wrap_hold = res_push && (epoch_q == EPOCH_LAST);
  // a last item may enter only if its result will find a buffer slot
  assign room      = ({1'b0, ocnt_q} + {2'b00, res_push}) < (3'd2 + {2'b00, out_pop});
  assign pop_o     = head_valid_i && !clr_active_q && !wrap_hold && (!head_last_i || room);

  lfstr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (pop_o),
    .raddr_i (head_pred_idx_i),
    .rdata_o (rdata)
  );

  always_comb begin
    word     = (fwd_valid_q && (fwd_addr_q == ex_pred_idx_q)) ? fwd_word_q : rdata;
    prev_ok  = ex_pred_ok_q && (word[WORD_W-1 -: EPOCH_W] == epoch_q);
    plen     = word[LEN_W-1:0];
    if (!prev_ok) begin
      len = LenOne;
    end else if (plen >= LenEdge) begin
      len = LenMax;
    end else begin
      len = plen + LenOne;
    end
    hit_now  = (len == LenMax);
    best_new = (len > best_q) ? len : best_q;
    hit_new  = hit_q || hit_now;
    best_ext = {{LONGEST_W{1'b0}}, best_new};
    wr_word  = {epoch_q, len};

    ram_we    = clr_active_q || ex_valid_q;
    ram_waddr = clr_active_q ? clr_addr_q : ex_val_idx_q;
    ram_wdata = clr_active_q ? '0 : wr_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      epoch_q      <= EPOCH_FIRST;
      ex_valid_q   <= 1'b0;
      fwd_valid_q  <= 1'b0;
      best_q       <= '0;
      hit_q        <= 1'b0;
      owr_q        <= 1'b0;
      ord_q        <= 1'b0;
      ocnt_q       <= 2'd0;
    end else begin
      ex_valid_q  <= pop_o;
      fwd_valid_q <= ex_valid_q;

      if (clr_active_q) begin
        clr_addr_q <= clr_addr_q + VALUE_BITS'(1);
        if (clr_addr_q == '1) begin
          clr_active_q <= 1'b0;
        end
      end

      if (ex_valid_q) begin
        if (ex_last_q) begin
          best_q <= '0;
          hit_q  <= 1'b0;
          if (epoch_q == EPOCH_LAST) begin
            epoch_q      <= EPOCH_FIRST;
            clr_active_q <= 1'b1;
            clr_addr_q   <= '0;
          end else begin
            epoch_q <= epoch_q + EPOCH_FIRST;
          end
        end else begin
          best_q <= best_new;
          hit_q  <= hit_new;
        end
      end

      if (res_push) begin
        owr_q <= ~owr_q;
      end
      if (out_pop) begin
        ord_q <= ~ord_q;
      end
      ocnt_q <= ocnt_q + {1'b0, res_push} - {1'b0, out_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ex_last_q     <= head_last_i;
      ex_pred_ok_q  <= head_pred_ok_i;
      ex_pred_idx_q <= head_pred_idx_i;
      ex_val_idx_q  <= head_val_idx_i;
    end
    fwd_addr_q <= ex_val_idx_q;
    fwd_word_q <= wr_word;
    if (res_push) begin
      obuf_q[owr_q].longest   <= best_ext[LONGEST_W-1:0];
      obuf_q[owr_q].saturated <= hit_new;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lfstr_checker.sv =====
`default_nettype none

module lfstr_checker import lfstr_pkg::*; #(
  parameter int VALUE_BITS = 12
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire logic                  is_last_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [LONGEST_W-1:0]  longest_o,
  input wire logic                  saturated_o
);

  logic [3:0] pending_q;
  logic       last_in, res_out;

  assign last_in = in_valid_i && !in_stall_o && is_last_i;
  assign res_out = out_valid_o && !out_stall_i;

  // last items accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 4'd0;
    end else begin
      pending_q <= pending_q + {3'd0, last_in} - {3'd0, res_out};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(longest_o) && $stable(saturated_o))
    else $error("stalled result changed");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out |-> pending_q != 4'd0)
    else $error("result without a last item");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> longest_o != '0)
    else $error("empty chain reported");

endmodule

bind longest_fixed_step_run_tracker_core lfstr_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_lfstr_checker (.*);

`default_nettype wire
